// ===== sv/abpg_pkg.sv =====
// shared types and constants for the alarm beep pattern generator
package abpg_pkg;

    typedef enum logic [3:0] {
        CMD_TICK    = 4'd0,
        CMD_SLOW10S = 4'd1,
        CMD_SLOW5S  = 4'd2,
        CMD_SLOW2S  = 4'd3,
        CMD_MID     = 4'd4,
        CMD_FAST    = 4'd5,
        CMD_CHIRP   = 4'd6,
        CMD_ONE0P2  = 4'd7,
        CMD_ONE5S   = 4'd8,
        CMD_CLEAR   = 4'd9,
        CMD_TEST    = 4'd10,
        CMD_PAUSE   = 4'd11
    } t_cmd;

    localparam int CMD_W   = 4;
    localparam int TICKS_W = 16;
    localparam int PAT_W   = 7;
    localparam int ON_W    = 6;
    localparam int OFF_W   = 7;

    typedef logic [PAT_W-1:0] t_pat;
    typedef logic [ON_W-1:0]  t_on;
    typedef logic [OFF_W-1:0] t_off;

    // one bit per pattern, at most one set; PB_REPEAT and PB_ONESHOT are group masks
    localparam t_pat PB_SLOW2S  = 7'h01;
    localparam t_pat PB_SLOW5S  = 7'h02;
    localparam t_pat PB_SLOW10S = 7'h04;
    localparam t_pat PB_MID     = 7'h08;
    localparam t_pat PB_FAST    = 7'h10;
    localparam t_pat PB_ONE0P2  = 7'h20;
    localparam t_pat PB_ONE5S   = 7'h40;
    localparam t_pat PB_REPEAT  = 7'h1F;
    localparam t_pat PB_ONESHOT = 7'h60;

    // on/off phase lengths in ticks
    localparam t_on  ON_REPEAT   = 6'd1;
    localparam t_on  ON_CHIRP    = 6'd1;
    localparam t_on  ON_ONE0P2   = 6'd2;
    localparam t_on  ON_ONE5S    = 6'd50;
    localparam t_off OFF_SLOW10S = 7'd99;
    localparam t_off OFF_SLOW5S  = 7'd49;
    localparam t_off OFF_SLOW2S  = 7'd19;
    localparam t_off OFF_MID     = 7'd9;
    localparam t_off OFF_FAST    = 7'd4;
    localparam t_off OFF_CHIRP   = 7'd1;
    localparam t_off OFF_NONE    = 7'd0;

    // pattern request decoded from a command
    typedef struct packed {
        logic valid;
        t_pat bits;
        t_on  on_ticks;
        t_off off_ticks;
        logic blockable;
        logic repeating;
    } t_req;

endpackage

// ===== sv/abpg_core.sv =====
// pattern state, counters and per-transaction next-state logic
module abpg_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [abpg_pkg::CMD_W-1:0]       i_cmd,
    input  logic [abpg_pkg::TICKS_W-1:0]     i_test_ticks,
    input  logic                             i_alarm_disable,
    output logic                             o_drive_next
);

    abpg_pkg::t_pat               r_pat, n_pat;
    logic                         r_chirp, n_chirp;
    logic                         r_chirp_rep, n_chirp_rep;
    logic                         r_paused, n_paused;
    logic                         r_test, n_test;
    logic [abpg_pkg::TICKS_W-1:0] r_test_left, n_test_left;
    abpg_pkg::t_on                r_on_rel, n_on_rel;
    abpg_pkg::t_off               r_off_rel, n_off_rel;
    abpg_pkg::t_on                r_on_left, n_on_left;
    abpg_pkg::t_off               r_off_left, n_off_left;
    logic                         r_drive, n_drive;
    abpg_pkg::t_req               req;

    // decode pattern requests
    always_comb begin
        req = '0;
        case (abpg_pkg::t_cmd'(i_cmd))
            abpg_pkg::CMD_SLOW10S: begin
                req = '{1'b1, abpg_pkg::PB_SLOW10S, abpg_pkg::ON_REPEAT,
                        abpg_pkg::OFF_SLOW10S, 1'b1, 1'b1};
            end
            abpg_pkg::CMD_SLOW5S: begin
                req = '{1'b1, abpg_pkg::PB_SLOW5S, abpg_pkg::ON_REPEAT,
                        abpg_pkg::OFF_SLOW5S, 1'b0, 1'b1};
            end
            abpg_pkg::CMD_SLOW2S: begin
                req = '{1'b1, abpg_pkg::PB_SLOW2S, abpg_pkg::ON_REPEAT,
                        abpg_pkg::OFF_SLOW2S, 1'b1, 1'b1};
            end
            abpg_pkg::CMD_MID: begin
                req = '{1'b1, abpg_pkg::PB_MID, abpg_pkg::ON_REPEAT,
                        abpg_pkg::OFF_MID, 1'b1, 1'b1};
            end
            abpg_pkg::CMD_FAST: begin
                req = '{1'b1, abpg_pkg::PB_FAST, abpg_pkg::ON_REPEAT,
                        abpg_pkg::OFF_FAST, 1'b1, 1'b1};
            end
            abpg_pkg::CMD_ONE0P2: begin
                req = '{1'b1, abpg_pkg::PB_ONE0P2, abpg_pkg::ON_ONE0P2,
                        abpg_pkg::OFF_NONE, 1'b0, 1'b0};
            end
            abpg_pkg::CMD_ONE5S: begin
                req = '{1'b1, abpg_pkg::PB_ONE5S, abpg_pkg::ON_ONE5S,
                        abpg_pkg::OFF_NONE, 1'b0, 1'b0};
            end
            default: begin
                req = '0;
            end
        endcase
    end

    always_comb begin
        n_pat       = r_pat;
        n_chirp     = r_chirp;
        n_chirp_rep = r_chirp_rep;
        n_paused    = r_paused;
        n_test      = r_test;
        n_test_left = r_test_left;
        n_on_rel    = r_on_rel;
        n_off_rel   = r_off_rel;
        n_on_left   = r_on_left;
        n_off_left  = r_off_left;
        n_drive     = r_drive;

        if (req.valid) begin
            // a running 5 s one-shot blocks most requests
            if (!(req.blockable && ((r_pat & abpg_pkg::PB_ONE5S) != '0)) &&
                ((r_pat & req.bits) == '0)) begin
                n_pat = req.bits;
                if (req.repeating) begin
                    n_paused = 1'b0;
                end
                n_on_rel   = req.on_ticks;
                n_off_rel  = req.off_ticks;
                n_on_left  = req.on_ticks;
                n_off_left = req.off_ticks;
            end
        end else begin
            case (abpg_pkg::t_cmd'(i_cmd))
                abpg_pkg::CMD_TICK: begin
                    if (r_test) begin
                        if (r_test_left != '0) begin
                            n_test_left = r_test_left - 1'b1;
                            n_drive     = 1'b1;
                        end else begin
                            n_test  = 1'b0;
                            n_drive = 1'b0;
                        end
                    end else if (((r_pat & abpg_pkg::PB_ONESHOT) == '0) && !r_chirp &&
                                 (((r_pat & abpg_pkg::PB_REPEAT) == '0) ||
                                  i_alarm_disable)) begin
                        n_drive = 1'b0;
                    end else if (r_on_left != '0) begin
                        n_on_left = r_on_left - 1'b1;
                        n_drive   = !r_paused && (r_pat != '0);
                    end else if (r_off_left != '0) begin
                        n_off_left = r_off_left - 1'b1;
                        n_drive    = 1'b0;
                    end else if (r_chirp) begin
                        // chirp plays its timing twice, then ends
                        if (r_chirp_rep) begin
                            n_chirp_rep = 1'b0;
                            n_on_left   = r_on_rel;
                            n_off_left  = r_off_rel;
                        end else begin
                            n_chirp = 1'b0;
                            n_drive = 1'b0;
                        end
                    end else if ((r_pat & abpg_pkg::PB_ONESHOT) != '0) begin
                        n_pat   = r_pat & ~abpg_pkg::PB_ONESHOT;
                        n_drive = 1'b0;
                    end else begin
                        n_on_left  = r_on_rel;
                        n_off_left = r_off_rel;
                    end
                end
                abpg_pkg::CMD_CHIRP: begin
                    if (!r_chirp) begin
                        n_chirp     = 1'b1;
                        n_chirp_rep = 1'b1;
                        n_on_rel    = abpg_pkg::ON_CHIRP;
                        n_off_rel   = abpg_pkg::OFF_CHIRP;
                        n_on_left   = abpg_pkg::ON_CHIRP;
                        n_off_left  = abpg_pkg::OFF_CHIRP;
                    end
                end
                abpg_pkg::CMD_CLEAR: begin
                    n_pat     = '0;
                    n_paused  = 1'b0;
                    n_on_rel  = '0;
                    n_off_rel = '0;
                end
                abpg_pkg::CMD_TEST: begin
                    n_test      = 1'b1;
                    n_test_left = i_test_ticks;
                end
                abpg_pkg::CMD_PAUSE: begin
                    n_paused = 1'b1;
                end
                default: begin
                    n_drive = r_drive;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= '0;
            r_chirp     <= 1'b0;
            r_chirp_rep <= 1'b0;
            r_paused    <= 1'b0;
            r_test      <= 1'b0;
            r_test_left <= '0;
            r_on_rel    <= '0;
            r_off_rel   <= '0;
            r_on_left   <= '0;
            r_off_left  <= '0;
            r_drive     <= 1'b0;
        end else if (i_accept) begin
            r_pat       <= n_pat;
            r_chirp     <= n_chirp;
            r_chirp_rep <= n_chirp_rep;
            r_paused    <= n_paused;
            r_test      <= n_test;
            r_test_left <= n_test_left;
            r_on_rel    <= n_on_rel;
            r_off_rel   <= n_off_rel;
            r_on_left   <= n_on_left;
            r_off_left  <= n_off_left;
            r_drive     <= n_drive;
        end
    end

    assign o_drive_next = n_drive;

endmodule

// ===== sv/alarm_beep_pattern_generator.sv =====
// alarm beep pattern generator: stream ports, config register and result buffer
// the result of a transaction is registered in the output buffer before it appears on m_axis
// throughput: one command or tick per cycle while the skid entry is empty; the state update is a single pass
// a two-entry output buffer (output register plus skid) decouples s_axis from m_axis
// reset (synchronous, active low) clears all patterns, counters, flags,
// the alarm disable bit and the output buffer valid flags; the drive state is off
module alarm_beep_pattern_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] test_ticks
    input  logic [3:0]  s_axis_tuser,   // [3:0] cmd
    // buzzer stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] buzzer_drive, [7:1] zero
);

    logic r_alarm_disable;
    logic r_out_valid;
    logic r_out_data;
    logic r_skid_valid;
    logic r_skid_data;
    logic in_acc;
    logic out_acc;
    logic cfg_wr;
    logic drive_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_alarm_disable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_disable <= 1'b0;
        end else if (cfg_wr) begin
            r_alarm_disable <= pwdata[0];
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_out_valid && m_axis_tready;

    abpg_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_acc),
        .i_cmd           (s_axis_tuser),
        .i_test_ticks    (s_axis_tdata),
        .i_alarm_disable (r_alarm_disable),
        .o_drive_next    (drive_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            // output stalled, park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_acc) begin
            r_out_data <= r_skid_valid ? r_skid_data : drive_next;
        end
        if (in_acc) begin
            r_skid_data <= drive_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_data};

endmodule
